// File: hw/rtl/jgrc_pkg.sv
// Shared widths, codes and record types for the jump-guarded relative clock.
`timescale 1ns / 1ps

package jgrc_pkg;

  // Field widths
  localparam int SEC_W  = 32;
  localparam int USEC_W = 20;
  localparam int JUMP_W = 8;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  // Microsecond difference and sum need two more bits than a field
  localparam int WIDE_W = USEC_W + 2;

  localparam logic [JUMP_W-1:0] MAX_JUMP_RESET = 8'd10;

  localparam logic signed [WIDE_W-1:0] USEC_PER_SEC_S  = 22'sd1000000;
  localparam logic signed [WIDE_W-1:0] USEC_NEG_SEC_S  = -22'sd1000000;
  localparam logic [WIDE_W-1:0]        USEC_ONE_SEC    = 22'd1000000;
  localparam logic [WIDE_W-1:0]        USEC_TWO_SEC    = 22'd2000000;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_SET    = 2'd1,
    OP_INIT   = 2'd2,
    OP_NONE   = 2'd3
  } jgrc_op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_NORMAL   = 2'd0,
    STAT_BACKWARD = 2'd1,
    STAT_JUMP     = 2'd2,
    STAT_UNUSED   = 2'd3
  } jgrc_status_t;

  // Seconds and microseconds pair
  typedef struct packed {
    logic [SEC_W-1:0]  sec;
    logic [USEC_W-1:0] usec;
  } jgrc_time_t;

  // Full block state: previous raw sample and relative clock
  typedef struct packed {
    jgrc_time_t prev;
    jgrc_time_t clock;
  } jgrc_state_t;

endpackage

// File: hw/rtl/jgrc_calc.sv
// Next-state and status logic for one request of the relative clock.
`timescale 1ns / 1ps

module jgrc_calc import jgrc_pkg::*; (
  input  jgrc_op_t                op,
  input  jgrc_time_t              raw,
  input  logic [JUMP_W-1:0]       max_jump,
  input  jgrc_state_t             cur,
  output jgrc_state_t             nxt,
  output jgrc_status_t            stat
);

  logic                      backward;
  logic [SEC_W-1:0]          dsec_raw;
  logic [SEC_W-1:0]          dsec_adj;
  logic [SEC_W-1:0]          dsec;
  logic signed [WIDE_W-1:0]  dus;
  logic signed [WIDE_W-1:0]  dus_norm;
  logic [USEC_W-1:0]         dus_use;
  logic                      q_pos;
  logic                      q_m1;
  logic                      q_m2;
  logic                      clamp;
  logic                      jump;
  logic [WIDE_W-1:0]         usum;
  logic [WIDE_W-1:0]         usum_norm;
  logic [1:0]                carry;
  jgrc_time_t                adv;

  // Compare the sample with the previous one as a pair
  assign backward = (raw.sec < cur.prev.sec) ||
                    ((raw.sec == cur.prev.sec) && (raw.usec < cur.prev.usec));

  // Raw differences
  assign dsec_raw = raw.sec - cur.prev.sec;
  assign dus      = $signed({2'b00, raw.usec}) - $signed({2'b00, cur.prev.usec});

  // Floor carry of the microsecond difference: one of +1, 0, -1, -2
  always_comb begin
    q_pos    = 1'b0;
    q_m1     = 1'b0;
    q_m2     = 1'b0;
    dus_norm = dus;
    if (dus >= USEC_PER_SEC_S) begin
      q_pos    = 1'b1;
      dus_norm = dus - USEC_PER_SEC_S;
    end else if (dus >= 0) begin
      dus_norm = dus;
    end else if (dus >= USEC_NEG_SEC_S) begin
      q_m1     = 1'b1;
      dus_norm = dus + USEC_PER_SEC_S;
    end else begin
      q_m2     = 1'b1;
      dus_norm = dus + USEC_PER_SEC_S + USEC_PER_SEC_S;
    end
  end

  // Apply the carry to the seconds difference; clamp a negative result to zero
  always_comb begin
    if (q_pos) begin
      dsec_adj = dsec_raw + 32'd1;
    end else if (q_m1) begin
      dsec_adj = dsec_raw - 32'd1;
    end else if (q_m2) begin
      dsec_adj = dsec_raw - 32'd2;
    end else begin
      dsec_adj = dsec_raw;
    end
  end

  assign clamp   = (q_m1 && (dsec_raw == '0)) || (q_m2 && (dsec_raw < 32'd2));
  assign dsec    = clamp ? '0 : dsec_adj;
  assign dus_use = clamp ? '0 : dus_norm[USEC_W-1:0];

  assign jump = dsec > {{(SEC_W-JUMP_W){1'b0}}, max_jump};

  // Add the microsecond difference to the clock and carry into seconds
  assign usum = {2'b00, cur.clock.usec} + {2'b00, dus_use};

  always_comb begin
    if (usum >= USEC_TWO_SEC) begin
      carry     = 2'd2;
      usum_norm = usum - USEC_TWO_SEC;
    end else if (usum >= USEC_ONE_SEC) begin
      carry     = 2'd1;
      usum_norm = usum - USEC_ONE_SEC;
    end else begin
      carry     = 2'd0;
      usum_norm = usum;
    end
  end

  assign adv.sec  = cur.clock.sec + dsec + {{(SEC_W-2){1'b0}}, carry};
  assign adv.usec = usum_norm[USEC_W-1:0];

  // Select the new state and status by opcode
  always_comb begin
    nxt  = cur;
    stat = STAT_NORMAL;
    case (op)
      OP_SAMPLE: begin
        nxt.prev = raw;
        if (backward || jump) begin
          nxt.clock.sec  = cur.clock.sec + 32'd1;
          nxt.clock.usec = '0;
          stat           = backward ? STAT_BACKWARD : STAT_JUMP;
        end else begin
          nxt.clock = adv;
        end
      end
      OP_SET: begin
        nxt.clock = raw;
      end
      OP_INIT: begin
        nxt.prev  = raw;
        nxt.clock = raw;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// File: hw/rtl/jump_guarded_relative_clock.sv
// Top level of the jump-guarded relative clock: request register, state and result register.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   opcode, seconds, microseconds
//   out      output     out_valid / out_stall rel_seconds, rel_microseconds, status
//   cfg      input      cfg_we                cfg_wdata (max_jump_seconds)
//
// One request per cycle unless the result stalls; a result is registered after the request.
// The request register feeds one pass of compare, subtract and add logic that
// updates the state and loads the result register in the same cycle.
// rst clears the state, the jump limit (to 10) and both valid flags.
// A stalled result holds; a full request register then holds too and in_stall rises.
`timescale 1ns / 1ps

module jump_guarded_relative_clock import jgrc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     opcode,
  input  logic [SEC_W-1:0]    seconds,
  input  logic [USEC_W-1:0]   microseconds,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SEC_W-1:0]    rel_seconds,
  output logic [USEC_W-1:0]   rel_microseconds,
  output logic [STAT_W-1:0]   status,
  input  logic                cfg_we,
  input  logic [JUMP_W-1:0]   cfg_wdata
);

  logic              req_valid;
  jgrc_op_t          req_op;
  jgrc_time_t        req_time;
  logic [JUMP_W-1:0] max_jump_seconds;
  jgrc_state_t       state;
  jgrc_state_t       state_next;
  jgrc_status_t      stat_next;
  logic              out_free;
  logic              advance;

  assign out_free = !out_valid || !out_stall;
  assign advance  = req_valid && out_free;
  assign in_stall = req_valid && !out_free;

  // Hold the jump limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_jump_seconds <= MAX_JUMP_RESET;
    end else if (cfg_we) begin
      max_jump_seconds <= cfg_wdata;
    end
  end

  // Take a request when the register is empty or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_op        <= jgrc_op_t'(opcode);
      req_time.sec  <= seconds;
      req_time.usec <= microseconds;
    end
  end

  jgrc_calc u_calc (
    .op       (req_op),
    .raw      (req_time),
    .max_jump (max_jump_seconds),
    .cur      (state),
    .nxt      (state_next),
    .stat     (stat_next)
  );

  // Advance the state with each request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Load the result register; drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rel_seconds      <= state_next.clock.sec;
      rel_microseconds <= state_next.clock.usec;
      status           <= stat_next;
    end
  end

endmodule
